[hw/rtl/min_max_rescaler_unit_assert.svh]
// Assertion macros for the rescaler top level.
`ifndef MIN_MAX_RESCALER_UNIT_ASSERT_SVH
`define MIN_MAX_RESCALER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on the rising edge of clk_i, skipped while rst_ni is low.
`define MMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge of clk_i, also during reset.
`define MMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MMR_ASSERT(lbl, prop, msg)
`define MMR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/mmr_pkg.sv]
// Types and constants of the min-max rescaler.
package mmr_pkg;

  localparam int BLOCK_DEPTH = 64;
  localparam int ADDR_W      = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);

  localparam int DATA_W      = 16;
  localparam int DIV_STEPS   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_OUT_MIN = 2'd0;
  localparam logic [1:0] REG_OUT_MAX = 2'd1;

  // Request to the divider: start pulse with operands.
  typedef struct packed {
    logic              start;
    logic [2*DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  // Divider status and result.
  typedef struct packed {
    logic              busy;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIVGO = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_e;

endpackage

[hw/rtl/min_max_rescaler_unit.sv]
// Top level of the min-max rescaler: load, min/max tracking and output pass.
//
// Input channel (in_valid_i, in_stall_o, sample_i, final_req_i): one item per
// cycle while a block loads; up to BLOCK_DEPTH samples are written to the
// sample RAM, later ones are dropped and set overrun_o on the block's results.
// The item with final_req_i high ends the block and starts the output pass;
// in_stall_o stays high until the last result has been handed to the output
// register.
// Output channel (out_valid_o, out_stall_i, scaled_o and flags): one item per
// stored sample, in stored order, with end_of_block_o on the last one.
// Each result passes a RAM read, a registered 16x16 multiply, a start state
// and the 16 steps of the one-bit-per-cycle divider, which sets the rate. A
// flat block skips the divider.
// While the receiver stalls, the result waits in the output register and the
// pass halts before its next result. Reset clears the counters, min/max,
// the drop flag and valid; out_min resets to 0 and out_max to 32767. The
// sample RAM needs no clearing since only entries written in the current block are read.
module min_max_rescaler_unit
  import mmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [15:0] sample_i,
  input  logic        final_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] scaled_o,
  output logic        end_of_block_o,
  output logic        flat_block_o,
  output logic        overrun_o
);

`include "min_max_rescaler_unit_assert.svh"

  state_e state_q, state_d;

  logic signed [15:0] out_min_q, out_max_q;
  logic signed [15:0] min_q, min_d, max_q, max_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic               drop_q, drop_d;
  logic [31:0]        prod_q;

  logic               in_acc, store_ok, slot_free, out_load, last_item;
  logic [16:0]        range17, mag17, span17, diff17, res17;
  logic               range_neg, flat;
  logic [15:0]        rdata;
  logic               ram_re;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic        out_valid_q;
  logic [15:0] scaled_q;
  logic        eob_q, flat_out_q, ovr_q;

  // Configuration registers; other indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_min_q <= 16'sd0;
      out_max_q <= 16'sd32767;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OUT_MIN: out_min_q <= cfg_wdata_i;
        REG_OUT_MAX: out_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input handshake and buffer space.
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_ok   = (count_q < CNT_W'(BLOCK_DEPTH));

  // Output range and block span; the divisor is the span.
  assign range17   = {out_max_q[15], out_max_q} - {out_min_q[15], out_min_q};
  assign range_neg = range17[16];
  assign mag17     = range_neg ? (17'd0 - range17) : range17;
  assign span17    = {max_q[15], max_q} - {min_q[15], min_q};
  assign flat      = (span17[15:0] == 16'd0);
  assign diff17    = {rdata[15], rdata} - {min_q[15], min_q};

  // Sample store.
  assign ram_re = (state_q == ST_READ);

  mmr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BLOCK_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && store_ok),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (sample_i),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Product register between the multiplier and the divider.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= mag17[15:0] * diff17[15:0];
    end
  end

  assign div_req.start    = (state_q == ST_DIVGO);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = span17[15:0];

  mmr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Result: out_min plus or minus the quotient magnitude, or out_min for a flat block.
  assign res17 = flat ? {out_min_q[15], out_min_q} :
                 range_neg ? ({out_min_q[15], out_min_q} - {1'b0, div_rsp.quotient}) :
                             ({out_min_q[15], out_min_q} + {1'b0, div_rsp.quotient});

  assign slot_free = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == ST_WAIT) && !div_rsp.busy && slot_free;
  assign last_item = ((CNT_W'(idx_q) + 1'b1) == count_q);

  // Sequencer for loading and the output pass.
  always_comb begin
    state_d = state_q;
    min_d   = min_q;
    max_d   = max_q;
    count_d = count_q;
    idx_d   = idx_q;
    drop_d  = drop_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            count_d = count_q + 1'b1;
            if (count_q == '0) begin
              min_d = sample_i;
              max_d = sample_i;
            end else begin
              if (sample_i > max_q) max_d = sample_i;
              if (sample_i < min_q) min_d = sample_i;
            end
          end else begin
            drop_d = 1'b1;
          end
          if (final_req_i) begin
            idx_d   = '0;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = flat ? ST_WAIT : ST_DIVGO;
      end
      ST_DIVGO: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_load) begin
          if (last_item) begin
            state_d = ST_LOAD;
            count_d = '0;
            min_d   = 16'sd0;
            max_d   = 16'sd0;
            drop_d  = 1'b0;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      min_q   <= 16'sd0;
      max_q   <= 16'sd0;
      count_q <= '0;
      idx_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      min_q   <= min_d;
      max_q   <= max_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      drop_q  <= drop_d;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      scaled_q   <= res17[15:0];
      eob_q      <= last_item;
      flat_out_q <= flat;
      ovr_q      <= drop_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_o       = scaled_q;
  assign end_of_block_o = eob_q;
  assign flat_block_o   = flat_out_q;
  assign overrun_o      = ovr_q;

  // The fill count never passes the buffer depth.
  `MMR_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CNT_W'(BLOCK_DEPTH)), "count above depth")
  // The divider is never running while a block loads.
  `MMR_ASSERT(a_div_idle_load, (state_q == ST_LOAD) |-> !div_rsp.busy, "divider busy in load")
  // The last result of a block returns the sequencer to a cleared load state.
  `MMR_ASSERT(a_end_clears, (out_load && last_item) |=> (state_q == ST_LOAD && count_q == '0 && !drop_q), "block not cleared")
  // A result of a flat block is out_min.
  `MMR_ASSERT(a_flat_value, (out_valid_q && flat_out_q) |-> (scaled_q == out_min_q), "flat result wrong")

endmodule

[hw/rtl/mmr_ram.sv]
// Generic simple dual-port RAM with one write and one registered read per cycle.
module mmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mmr_div.sv]
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
module mmr_div
  import mmr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [2*DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0]   divisor_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W+1:0]   trial;
  logic                ge;

  // The upper half of the dividend is known to be below the divisor, so the
  // quotient fits in DATA_W bits and DIV_STEPS steps suffice.
  always_comb begin
    trial = {1'b0, acc_q[2*DATA_W-1:DATA_W-1]} - {2'b00, divisor_q};
    ge    = ~trial[DATA_W+1];
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      acc_d = req_i.dividend;
      cnt_d = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      acc_d = {(ge ? trial[DATA_W-1:0] : acc_q[2*DATA_W-2:DATA_W-1]),
               acc_q[DATA_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working register and divisor.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (req_i.start) begin
      divisor_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy     = (cnt_q != '0);
  assign rsp_o.quotient = acc_q[DATA_W-1:0];

endmodule
